FILE: design/reduce_flit_beat_assembler_macros.svh
// assertion helpers for the beat assembler
`ifndef REDUCE_FLIT_BEAT_ASSEMBLER_MACROS_SVH
`define REDUCE_FLIT_BEAT_ASSEMBLER_MACROS_SVH

// check that a condition holds at every edge out of reset
`define RFBA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// check that a trigger implies a consequence in the next cycle
`define RFBA_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/rfba_pkg.sv
package rfba_pkg;

  localparam int MAX_SLICES_DEF  = 8;
  localparam int READY_DEPTH_DEF = 4;
  localparam int FLIT_BITS       = 128;

  localparam logic [3:0] ST_ACCEPTED     = 4'd0;
  localparam logic [3:0] ST_BEAT_READY   = 4'd1;
  localparam logic [3:0] ST_COMPLETE     = 4'd2;
  localparam logic [3:0] ST_BACKPRESSURE = 4'd3;
  localparam logic [3:0] ST_ROUTE        = 4'd4;
  localparam logic [3:0] ST_EXTRA        = 4'd5;
  localparam logic [3:0] ST_GAP          = 4'd6;
  localparam logic [3:0] ST_TAIL_SHAPE   = 4'd7;
  localparam logic [3:0] ST_BAD_SHAPE    = 4'd8;
  localparam logic [3:0] ST_SLICE        = 4'd9;
  localparam logic [3:0] ST_EMPTY        = 4'd10;

  localparam logic [2:0] REG_ROUTE_KEY      = 3'd0;
  localparam logic [2:0] REG_FLIT_COUNT     = 3'd1;
  localparam logic [2:0] REG_TAIL_LEN       = 3'd2;
  localparam logic [2:0] REG_BEAT_SLICES    = 3'd3;
  localparam logic [2:0] REG_READY_CAPACITY = 3'd4;
  localparam logic [2:0] REG_VECTOR_BEATS   = 3'd5;
  localparam logic [2:0] REG_LANES_PER_BEAT = 3'd6;
  localparam logic [2:0] REG_TAIL_LANES     = 3'd7;

  typedef struct packed {
    logic [3:0] status;
    logic       commit;
    logic       emit;
    logic       final_flit;
  } chk_t;

endpackage

FILE: design/rfba_slice_mem.sv
module rfba_slice_mem #(
  parameter int DEPTH = 40,
  parameter int AW    = 6
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  logic [127:0]   wdata,
  input  logic           re,
  input  logic [AW-1:0]  raddr,
  output logic [127:0]   rdata
);

  logic [127:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/rfba_flit_check.sv
module rfba_flit_check #(
  parameter int CW = 4,
  parameter int UW = 3
) (
  input  logic [59:0]   route_key,
  input  logic [15:0]   flit_count,
  input  logic [7:0]    tail_len,
  input  logic [15:0]   expected_seq,
  input  logic [CW-1:0] frag_count,
  input  logic [CW-1:0] spb,
  input  logic [UW-1:0] used,
  input  logic [UW-1:0] cap,
  input  logic [59:0]   flit_route,
  input  logic [15:0]   seq_id,
  input  logic [7:0]    bit_len,
  input  logic          is_tail,
  input  logic [127:0]  payload,
  output rfba_pkg::chk_t chk
);

  logic          final_flit;
  logic          emit;
  logic [7:0]    want_len;
  logic [127:0]  unused_mask;
  logic [CW:0]   frag_next;
  logic [15:0]   seq_next;

  always_comb begin
    final_flit  = (17'(expected_seq) + 17'd1) == 17'(flit_count);
    want_len    = final_flit ? tail_len : 8'(rfba_pkg::FLIT_BITS);
    unused_mask = {128{1'b1}} << bit_len;
    frag_next   = (CW+1)'(frag_count) + (CW+1)'(1);
    emit        = (frag_next >= (CW+1)'(spb)) || final_flit;
    seq_next    = expected_seq + 16'd1;
    chk.emit       = emit;
    chk.final_flit = final_flit;
    chk.commit     = 1'b0;
    if (flit_route != route_key) begin
      chk.status = rfba_pkg::ST_ROUTE;
    end else if (expected_seq == flit_count) begin
      chk.status = rfba_pkg::ST_EXTRA;
    end else if (seq_id != expected_seq) begin
      chk.status = rfba_pkg::ST_GAP;
    end else if ((is_tail != final_flit) || (bit_len != want_len)) begin
      chk.status = rfba_pkg::ST_TAIL_SHAPE;
    end else if ((route_key[59:44] == 16'd0) || (bit_len == 8'd0) ||
                 (bit_len > 8'(rfba_pkg::FLIT_BITS))) begin
      chk.status = rfba_pkg::ST_BAD_SHAPE;
    end else if (|(payload & unused_mask)) begin
      chk.status = rfba_pkg::ST_SLICE;
    end else if (emit && (used >= cap)) begin
      chk.status = rfba_pkg::ST_BACKPRESSURE;
    end else begin
      chk.commit = 1'b1;
      if (seq_next == flit_count) begin
        chk.status = rfba_pkg::ST_COMPLETE;
      end else if (emit) begin
        chk.status = rfba_pkg::ST_BEAT_READY;
      end else begin
        chk.status = rfba_pkg::ST_ACCEPTED;
      end
    end
  end

endmodule

FILE: design/reduce_flit_beat_assembler.sv
// Pipeline: a request is registered in the s1 stage, alongside the slice memory
// read, and then in the output registers; further slices of a pop follow it.
// Throughput: one flit request per cycle while in_stall is low; a pop stalls
// the input until its slices are read, bound by the single slice-memory read port.
// Reset: synchronous active-low rst_n clears counters, queue pointers and
// output valid; slice memory and beat metadata are not cleared.
`include "reduce_flit_beat_assembler_macros.svh"

module reduce_flit_beat_assembler #(
  parameter int MAX_SLICES  = rfba_pkg::MAX_SLICES_DEF,
  parameter int READY_DEPTH = rfba_pkg::READY_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [59:0]  cfg_wdata,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         in_op,
  input  logic [59:0]  in_flit_route,
  input  logic [15:0]  in_seq_id,
  input  logic [7:0]   in_bit_len,
  input  logic         in_is_tail,
  input  logic [63:0]  in_payload_low,
  input  logic [63:0]  in_payload_high,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [3:0]   out_status,
  output logic [15:0]  out_beat_id,
  output logic [2:0]   out_slice_index,
  output logic [7:0]   out_lane_cnt,
  output logic [63:0]  out_out_low,
  output logic [63:0]  out_out_high,
  output logic         out_last
);

  localparam int NSLOT  = READY_DEPTH + 1;
  localparam int SLW    = $clog2(NSLOT);
  localparam int CW     = $clog2(MAX_SLICES + 1);
  localparam int UW     = $clog2(READY_DEPTH + 1);
  localparam int MDEPTH = NSLOT * MAX_SLICES;
  localparam int AW     = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;

  logic [59:0] route_key_r;
  logic [15:0] flit_count_r;
  logic [7:0]  tail_len_r;
  logic [3:0]  spb_cfg_r;
  logic [2:0]  cap_cfg_r;
  logic [15:0] vector_beats_r;
  logic [7:0]  lanes_per_beat_r;
  logic [7:0]  tail_lanes_r;

  logic [15:0]    exp_seq_r, exp_seq_nxt;
  logic [15:0]    next_beat_r, next_beat_nxt;
  logic [CW-1:0]  frag_r, frag_nxt;
  logic [SLW-1:0] head_r, head_nxt;
  logic [UW-1:0]  used_r, used_nxt;

  logic [15:0]   meta_id    [NSLOT];
  logic [7:0]    meta_lanes [NSLOT];
  logic [CW-1:0] meta_cnt   [NSLOT];

  logic           pop_act_r, pop_act_nxt;
  logic [CW-1:0]  pop_idx_r, pop_idx_nxt;
  logic [SLW-1:0] pop_slot_r, pop_slot_nxt;

  logic          s1_v_r, s1_v_nxt;
  logic [3:0]    s1_status_r, s1_status_nxt;
  logic [15:0]   s1_id_r, s1_id_nxt;
  logic [CW-1:0] s1_idx_r, s1_idx_nxt;
  logic [7:0]    s1_lanes_r, s1_lanes_nxt;
  logic          s1_data_r, s1_data_nxt;
  logic          s1_last_r, s1_last_nxt;

  logic [CW-1:0]  spb_eff;
  logic [UW-1:0]  cap_eff;
  logic [SLW:0]   fill_sum;
  logic [SLW-1:0] fill_slot;
  logic [SLW-1:0] rd_slot;
  logic [CW-1:0]  rd_idx;
  logic           out_free, s1_free, in_acc;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [127:0]   mem_rdata;
  logic           beat_final;
  rfba_pkg::chk_t chk;

  always_comb begin
    if (spb_cfg_r == 4'd0) begin
      spb_eff = CW'(1);
    end else if (32'(spb_cfg_r) > MAX_SLICES) begin
      spb_eff = CW'(MAX_SLICES);
    end else begin
      spb_eff = CW'(spb_cfg_r);
    end
    if (cap_cfg_r == 3'd0) begin
      cap_eff = UW'(1);
    end else if (32'(cap_cfg_r) > READY_DEPTH) begin
      cap_eff = UW'(READY_DEPTH);
    end else begin
      cap_eff = UW'(cap_cfg_r);
    end
    fill_sum = (SLW+1)'(head_r) + (SLW+1)'(used_r);
    if (32'(fill_sum) >= NSLOT) begin
      fill_slot = SLW'(32'(fill_sum) - NSLOT);
    end else begin
      fill_slot = SLW'(fill_sum);
    end
  end

  rfba_flit_check #(.CW(CW), .UW(UW)) u_check (
    .route_key    (route_key_r),
    .flit_count   (flit_count_r),
    .tail_len     (tail_len_r),
    .expected_seq (exp_seq_r),
    .frag_count   (frag_r),
    .spb          (spb_eff),
    .used         (used_r),
    .cap          (cap_eff),
    .flit_route   (in_flit_route),
    .seq_id       (in_seq_id),
    .bit_len      (in_bit_len),
    .is_tail      (in_is_tail),
    .payload      ({in_payload_high, in_payload_low}),
    .chk          (chk)
  );

  assign out_free = !out_valid || !out_stall;
  assign s1_free  = !s1_v_r || out_free;
  assign in_stall = !s1_free || pop_act_r;
  assign in_acc   = in_valid && !in_stall;
  assign beat_final = (17'(next_beat_r) + 17'd1) == 17'(vector_beats_r);

  always_comb begin
    exp_seq_nxt   = exp_seq_r;
    next_beat_nxt = next_beat_r;
    frag_nxt      = frag_r;
    head_nxt      = head_r;
    used_nxt      = used_r;
    pop_act_nxt   = pop_act_r;
    pop_idx_nxt   = pop_idx_r;
    pop_slot_nxt  = pop_slot_r;
    s1_v_nxt      = s1_v_r && !out_free;
    s1_status_nxt = s1_status_r;
    s1_id_nxt     = s1_id_r;
    s1_idx_nxt    = s1_idx_r;
    s1_lanes_nxt  = s1_lanes_r;
    s1_data_nxt   = s1_data_r;
    s1_last_nxt   = s1_last_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    rd_slot       = pop_slot_r;
    rd_idx        = pop_idx_r;
    if (in_acc && !in_op) begin
      s1_v_nxt      = 1'b1;
      s1_status_nxt = chk.status;
      s1_id_nxt     = 16'd0;
      s1_idx_nxt    = '0;
      s1_lanes_nxt  = 8'd0;
      s1_data_nxt   = 1'b0;
      s1_last_nxt   = 1'b1;
      if (chk.commit) begin
        mem_we      = 1'b1;
        exp_seq_nxt = exp_seq_r + 16'd1;
        if (chk.emit) begin
          used_nxt      = used_r + UW'(1);
          next_beat_nxt = next_beat_r + 16'd1;
          frag_nxt      = '0;
        end else begin
          frag_nxt = frag_r + CW'(1);
        end
      end
    end else if (in_acc && (used_r == '0)) begin
      s1_v_nxt      = 1'b1;
      s1_status_nxt = rfba_pkg::ST_EMPTY;
      s1_id_nxt     = 16'd0;
      s1_idx_nxt    = '0;
      s1_lanes_nxt  = 8'd0;
      s1_data_nxt   = 1'b0;
      s1_last_nxt   = 1'b1;
    end else if (in_acc || (pop_act_r && s1_free)) begin
      if (in_acc) begin
        rd_slot = head_r;
        rd_idx  = '0;
        used_nxt = used_r - UW'(1);
        head_nxt = (32'(head_r) == NSLOT - 1) ? '0 : head_r + SLW'(1);
      end
      mem_re        = 1'b1;
      s1_v_nxt      = 1'b1;
      s1_status_nxt = rfba_pkg::ST_ACCEPTED;
      s1_id_nxt     = meta_id[rd_slot];
      s1_idx_nxt    = rd_idx;
      s1_lanes_nxt  = meta_lanes[rd_slot];
      s1_data_nxt   = rd_idx < meta_cnt[rd_slot];
      s1_last_nxt   = ((CW+1)'(rd_idx) + (CW+1)'(1)) == (CW+1)'(spb_eff);
      pop_act_nxt   = !s1_last_nxt;
      pop_idx_nxt   = rd_idx + CW'(1);
      pop_slot_nxt  = rd_slot;
    end
  end

  assign mem_waddr = AW'(32'(fill_slot) * MAX_SLICES + 32'(frag_r));
  assign mem_raddr = AW'(32'(rd_slot) * MAX_SLICES + 32'(rd_idx));

  rfba_slice_mem #(.DEPTH(MDEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata ({in_payload_high, in_payload_low}),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (in_acc && !in_op && chk.commit && chk.emit) begin
      meta_id[fill_slot]    <= next_beat_r;
      meta_lanes[fill_slot] <= beat_final ? tail_lanes_r : lanes_per_beat_r;
      meta_cnt[fill_slot]   <= frag_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_key_r      <= 60'd0;
      flit_count_r     <= 16'd1;
      tail_len_r       <= 8'd128;
      spb_cfg_r        <= 4'd8;
      cap_cfg_r        <= 3'd4;
      vector_beats_r   <= 16'd1;
      lanes_per_beat_r <= 8'd32;
      tail_lanes_r     <= 8'd32;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rfba_pkg::REG_ROUTE_KEY:      route_key_r      <= cfg_wdata;
        rfba_pkg::REG_FLIT_COUNT:     flit_count_r     <= cfg_wdata[15:0];
        rfba_pkg::REG_TAIL_LEN:       tail_len_r       <= cfg_wdata[7:0];
        rfba_pkg::REG_BEAT_SLICES:    spb_cfg_r        <= cfg_wdata[3:0];
        rfba_pkg::REG_READY_CAPACITY: cap_cfg_r        <= cfg_wdata[2:0];
        rfba_pkg::REG_VECTOR_BEATS:   vector_beats_r   <= cfg_wdata[15:0];
        rfba_pkg::REG_LANES_PER_BEAT: lanes_per_beat_r <= cfg_wdata[7:0];
        rfba_pkg::REG_TAIL_LANES:     tail_lanes_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_seq_r   <= 16'd0;
      next_beat_r <= 16'd0;
      frag_r      <= '0;
      head_r      <= '0;
      used_r      <= '0;
      pop_act_r   <= 1'b0;
      s1_v_r      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      exp_seq_r   <= exp_seq_nxt;
      next_beat_r <= next_beat_nxt;
      frag_r      <= frag_nxt;
      head_r      <= head_nxt;
      used_r      <= used_nxt;
      pop_act_r   <= pop_act_nxt;
      s1_v_r      <= s1_v_nxt;
      if (out_free) begin
        out_valid <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    pop_idx_r   <= pop_idx_nxt;
    pop_slot_r  <= pop_slot_nxt;
    s1_status_r <= s1_status_nxt;
    s1_id_r     <= s1_id_nxt;
    s1_idx_r    <= s1_idx_nxt;
    s1_lanes_r  <= s1_lanes_nxt;
    s1_data_r   <= s1_data_nxt;
    s1_last_r   <= s1_last_nxt;
    if (out_free && s1_v_r) begin
      out_status      <= s1_status_r;
      out_beat_id     <= s1_id_r;
      out_slice_index <= 3'(s1_idx_r);
      out_lane_cnt    <= s1_lanes_r;
      out_out_low     <= s1_data_r ? mem_rdata[63:0] : 64'd0;
      out_out_high    <= s1_data_r ? mem_rdata[127:64] : 64'd0;
      out_last        <= s1_last_r;
    end
  end

  `RFBA_ASSERT_ALWAYS(a_used_bound, 32'(used_r) <= READY_DEPTH)
  `RFBA_ASSERT_ALWAYS(a_frag_bound, 32'(frag_r) < MAX_SLICES)
  `RFBA_ASSERT_NEXT(a_pop_holds_input, pop_act_r, in_stall || !pop_act_r)
  `RFBA_ASSERT_NEXT(a_no_write_in_pop, pop_act_r, !mem_we || !pop_act_r)

endmodule
